### rtl/core/lspv_pkg.sv
// Shared types, codes and helpers of the looped sample playback voice.
// No dependencies; every other file of the block but lspv_out_if refers to it by scoped names.
package lspv_pkg;

  localparam int unsigned StoreDepth = 4096;
  localparam int unsigned AddrW      = 12;
  localparam int unsigned LenW       = 13;
  localparam int unsigned FracBits   = 16;
  localparam int unsigned VwW        = 20;
  localparam int unsigned CfgIdxW    = 3;
  localparam int unsigned CfgDataW   = 13;

  typedef enum logic [1:0] {
    CMD_LOAD   = 2'd0,
    CMD_START  = 2'd1,
    CMD_RENDER = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  localparam logic [1:0] LOOP_OFF  = 2'd0;
  localparam logic [1:0] LOOP_FWD  = 2'd1;
  localparam logic [1:0] LOOP_PING = 2'd2;

  localparam logic [1:0] FMT_S8  = 2'd0;
  localparam logic [1:0] FMT_S16 = 2'd1;

  localparam logic [CfgIdxW-1:0] REG_LOOP_MODE  = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LOOP_FIRST = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_LOOP_LAST  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LENGTH     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_FORMAT     = 3'd4;

  typedef struct packed {
    cmd_e                cmd;
    logic [AddrW-1:0]    address;
    logic [31:0]         word;
    logic [7:0]          step_whole;
    logic [FracBits-1:0] step_frac;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic [1:0]       wrap_mode;
    logic [AddrW-1:0] loop_first;
    logic [LenW-1:0]  loop_last_excl;
    logic [LenW-1:0]  sample_length;
    logic [1:0]       sample_format;
  } cfg_t;

  // Normalize a stored word to Q1.23; the 32-bit form drops the low byte.
  function automatic logic signed [23:0] to_q23(logic [1:0] fmt, logic [31:0] w);
    logic signed [23:0] v;
    unique case (fmt)
      FMT_S8:  v = {w[7:0], 16'h0000};
      FMT_S16: v = {w[15:0], 8'h00};
      default: v = w[31:8];
    endcase
    return v;
  endfunction

endpackage

### rtl/core/lspv_in_if.sv
// Command channel of the sample playback voice.
// Depends on lspv_pkg for field widths.
interface lspv_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    cmd;
  logic [lspv_pkg::AddrW-1:0]    address;
  logic [31:0]                   sample_word;
  logic [7:0]                    step_whole;
  logic [15:0]                   step_fraction;

  modport source (output valid, cmd, address, sample_word, step_whole, step_fraction,
                  input ready);
  modport sink (input valid, cmd, address, sample_word, step_whole, step_fraction,
                output ready);
endinterface

### rtl/core/lspv_out_if.sv
// Result channel of the sample playback voice.
// No dependencies.
interface lspv_out_if;
  logic               valid;
  logic               ready;
  logic signed [23:0] frame_value;
  logic               voice_active;
  logic               voice_ended;

  modport source (output valid, frame_value, voice_active, voice_ended, input ready);
  modport sink (input valid, frame_value, voice_active, voice_ended, output ready);
endinterface

### rtl/core/lspv_front.sv
// Front end: accepts commands, decodes them and pushes them to the queue.
// Depends on lspv_pkg and lspv_in_if.
module lspv_front (
  lspv_in_if.sink                 req,
  input  lspv_pkg::q_stat_t       q_stat_i,
  output lspv_pkg::push_t         push_o
);

  logic [lspv_pkg::FracBits+23:0] frac_wide;

  // Rescale the 1/65536 step fraction to the internal fraction width.
  assign frac_wide = {24'd0, req.step_fraction} << lspv_pkg::FracBits;

  assign req.ready               = !q_stat_i.full;
  assign push_o.valid            = req.valid && !q_stat_i.full;
  assign push_o.item.cmd         = lspv_pkg::cmd_e'(req.cmd);
  assign push_o.item.address     = req.address;
  assign push_o.item.word        = req.sample_word;
  assign push_o.item.step_whole  = req.step_whole;
  assign push_o.item.step_frac   = frac_wide[lspv_pkg::FracBits+15:16];

endmodule

### rtl/core/lspv_queue.sv
// Two-entry queue between the front end and the execution back end.
// Depends on lspv_pkg.
module lspv_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lspv_pkg::push_t   push_i,
  input  logic              pop_i,
  output lspv_pkg::item_t   head_o,
  output lspv_pkg::q_stat_t stat_o
);

  lspv_pkg::item_t slot_q [2];
  logic            wr_q, wr_d, rd_q, rd_d;
  logic [1:0]      cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign do_push = push_i.valid && (cnt_q != 2'd2);
  assign do_pop  = pop_i && (cnt_q != 2'd0);
  assign wr_d    = do_push ? ~wr_q : wr_q;
  assign rd_d    = do_pop ? ~rd_q : rd_q;

  always_comb begin
    cnt_d = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= push_i.item;
    end
  end

  assign head_o       = slot_q[rd_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.empty = (cnt_q == 2'd0);

endmodule

### rtl/core/lspv_back.sv
// Back end: sample memory, interpolation, position advance with loop folding
// and the result register. Depends on lspv_pkg and lspv_out_if.
module lspv_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  lspv_pkg::cfg_t    cfg_i,
  input  lspv_pkg::item_t   head_i,
  input  logic              q_empty_i,
  output logic              pop_o,
  lspv_out_if.source        rsp
);

  localparam int unsigned AW = lspv_pkg::AddrW;
  localparam int unsigned LW = lspv_pkg::LenW;
  localparam int unsigned FB = lspv_pkg::FracBits;
  localparam int unsigned VW = lspv_pkg::VwW;
  localparam logic [FB:0] FracOne = (FB+1)'(1) << FB;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RCUR = 4'd1;
  localparam logic [3:0] S_RNXT = 4'd2;
  localparam logic [3:0] S_MUL1 = 4'd3;
  localparam logic [3:0] S_MUL2 = 4'd4;
  localparam logic [3:0] S_SUM  = 4'd5;
  localparam logic [3:0] S_DIV  = 4'd6;
  localparam logic [3:0] S_FOLD = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]          state_q, state_d;
  logic [VW-1:0]       vw_q, vw_d;
  logic [FB-1:0]       vf_q, vf_d;
  logic [AW-1:0]       pi_q, pi_d;
  logic [FB-1:0]       pf_q, pf_d;
  logic                back_q, back_d;
  logic                playing_q, playing_d;
  logic                ended_q, ended_d;
  logic                rsp_valid_q, rsp_valid_d;
  logic [4:0]          cnt_q, cnt_d;

  // Payload registers.
  lspv_pkg::item_t     it_q;
  logic [1:0]          lm_q;
  logic [AW-1:0]       nxt_q;
  logic                has_q;
  logic [FB:0]         mix_q;
  logic signed [23:0]  cur_q, nv_q, frame_q;
  logic signed [FB+25:0] pa_q, pb_q;
  logic [VW-1:0]       dq_q;
  logic [14:0]         rem_q;
  logic [13:0]         period_q;
  logic signed [23:0]  rsp_frame_q;
  logic                rsp_active_q, rsp_ended_q;
  logic [31:0]         mem_q [lspv_pkg::StoreDepth];
  logic [31:0]         rdata_q;

  // Effective length and loop mode, next sample index and interpolation weight.
  logic [LW-1:0]       len_c, rel_c, ls_c, le_c, limit_c, nxt_c;
  logic [1:0]          lm_c;
  logic                has_c;
  logic [FB:0]         mix_c;

  always_comb begin
    len_c = (cfg_i.sample_length > LW'(lspv_pkg::StoreDepth)) ?
            LW'(lspv_pkg::StoreDepth) : cfg_i.sample_length;
    ls_c  = {1'b0, cfg_i.loop_first};
    le_c  = cfg_i.loop_last_excl;
    rel_c = {1'b0, pi_q};
    lm_c  = ((cfg_i.wrap_mode == lspv_pkg::LOOP_FWD || cfg_i.wrap_mode == lspv_pkg::LOOP_PING)
             && len_c != '0 && ls_c < le_c && le_c <= len_c) ? cfg_i.wrap_mode
            : lspv_pkg::LOOP_OFF;
    limit_c = (lm_c != lspv_pkg::LOOP_OFF) ? le_c : len_c;
    has_c = 1'b1;
    nxt_c = '0;
    if (!back_q || lm_c != lspv_pkg::LOOP_PING) begin
      if (rel_c + LW'(1) < limit_c) begin
        nxt_c = rel_c + LW'(1);
      end else if (lm_c == lspv_pkg::LOOP_FWD) begin
        nxt_c = ls_c;
      end else if (lm_c == lspv_pkg::LOOP_PING) begin
        nxt_c = (rel_c > ls_c) ? rel_c - LW'(1) : ls_c;
      end else begin
        has_c = 1'b0;
      end
    end else if (ls_c + LW'(1) == le_c) begin
      nxt_c = ls_c;
    end else begin
      nxt_c = (rel_c > ls_c) ? rel_c - LW'(1) : ls_c + LW'(1);
      if (nxt_c >= le_c) begin
        nxt_c = le_c - LW'(1);
      end
    end
    mix_c = (nxt_c < rel_c) ? FracOne - {1'b0, pf_q} : {1'b0, pf_q};
  end

  // Sum, advance and fold arithmetic.
  logic signed [FB+26:0] acc_c, rnd_c;
  logic [FB:0]           fsum_c;
  logic [VW-1:0]         vwn_c;
  logic [LW-1:0]         span_c;
  logic [14:0]           remsh_c, t_c, vp0_c, vp_c, p2_c;

  always_comb begin
    acc_c   = pa_q + pb_q;
    rnd_c   = acc_c + (FB+27)'(FracOne >> 1);
    fsum_c  = {1'b0, vf_q} + {1'b0, it_q.step_frac};
    vwn_c   = vw_q + VW'(it_q.step_whole) + VW'(fsum_c[FB]);
    span_c  = le_c - ls_c;
    remsh_c = {rem_q[13:0], dq_q[VW-1]};
    t_c     = rem_q + 15'(span_c);
    vp0_c   = (t_c >= {1'b0, period_q}) ? t_c - {1'b0, period_q} : t_c;
    vp_c    = vp0_c + 15'(ls_c);
    p2_c    = {1'b0, le_c, 1'b0} - 15'd2 - vp_c;
  end

  logic [AW-1:0] rd_addr;
  logic          mem_we;
  assign rd_addr = (state_q == S_RCUR) ? pi_q : nxt_q;
  assign mem_we  = (state_q == S_IDLE) && !q_empty_i && (head_i.cmd == lspv_pkg::CMD_LOAD);
  assign pop_o   = (state_q == S_IDLE) && !q_empty_i;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[head_i.address] <= head_i.word;
    end
    rdata_q <= mem_q[rd_addr];
  end

  // Control sequencer.
  always_comb begin
    state_d     = state_q;
    vw_d        = vw_q;
    vf_d        = vf_q;
    pi_d        = pi_q;
    pf_d        = pf_q;
    back_d      = back_q;
    playing_d   = playing_q;
    ended_d     = ended_q;
    cnt_d       = cnt_q;
    rsp_valid_d = rsp_valid_q && !rsp.ready;
    unique case (state_q)
      S_IDLE: begin
        if (!q_empty_i) begin
          ended_d = 1'b0;
          state_d = S_OUT;
          unique case (head_i.cmd)
            lspv_pkg::CMD_START: begin
              vw_d      = '0;
              vf_d      = '0;
              pi_d      = '0;
              pf_d      = '0;
              back_d    = 1'b0;
              playing_d = 1'b1;
            end
            lspv_pkg::CMD_RENDER: begin
              if (playing_q) begin
                if (rel_c >= len_c) begin
                  playing_d = 1'b0;
                  ended_d   = 1'b1;
                end else begin
                  state_d = S_RCUR;
                end
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_RCUR: state_d = S_RNXT;
      S_RNXT: state_d = S_MUL1;
      S_MUL1: state_d = S_MUL2;
      S_MUL2: state_d = S_SUM;
      S_SUM: begin
        vf_d    = fsum_c[FB-1:0];
        state_d = S_OUT;
        if (lm_q == lspv_pkg::LOOP_OFF) begin
          vw_d = vwn_c;
          pi_d = vwn_c[AW-1:0];
          pf_d = fsum_c[FB-1:0];
          if (vwn_c >= VW'(len_c)) begin
            playing_d = 1'b0;
            ended_d   = 1'b1;
          end
        end else if (vwn_c < VW'(le_c)) begin
          vw_d   = vwn_c;
          back_d = 1'b0;
          pi_d   = vwn_c[AW-1:0];
          pf_d   = fsum_c[FB-1:0];
        end else if (ls_c + LW'(1) == le_c) begin
          vw_d   = VW'(le_c);
          back_d = 1'b0;
          pi_d   = cfg_i.loop_first;
          pf_d   = '0;
        end else begin
          cnt_d   = '0;
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        cnt_d = cnt_q + 5'd1;
        if (cnt_q == 5'(VW-1)) begin
          state_d = S_FOLD;
        end
      end
      S_FOLD: begin
        vw_d    = VW'(le_c) + VW'(rem_q);
        pf_d    = vf_q;
        state_d = S_OUT;
        if (lm_q == lspv_pkg::LOOP_FWD || vp_c < 15'(le_c) - 15'd1) begin
          back_d = 1'b0;
          pi_d   = vp_c[AW-1:0];
        end else begin
          back_d = 1'b1;
          if (p2_c > 15'(ls_c) && vf_q != '0) begin
            pi_d = p2_c[AW-1:0] - AW'(1);
            pf_d = FB'(FracOne - {1'b0, vf_q});
          end else begin
            pi_d = p2_c[AW-1:0];
          end
        end
      end
      S_OUT: begin
        if (!rsp_valid_q || rsp.ready) begin
          rsp_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vw_q        <= '0;
      vf_q        <= '0;
      pi_q        <= '0;
      pf_q        <= '0;
      back_q      <= 1'b0;
      playing_q   <= 1'b0;
      ended_q     <= 1'b0;
      cnt_q       <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      vw_q        <= vw_d;
      vf_q        <= vf_d;
      pi_q        <= pi_d;
      pf_q        <= pf_d;
      back_q      <= back_d;
      playing_q   <= playing_d;
      ended_q     <= ended_d;
      cnt_q       <= cnt_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        it_q    <= head_i;
        lm_q    <= lm_c;
        nxt_q   <= nxt_c[AW-1:0];
        has_q   <= has_c;
        mix_q   <= mix_c;
        frame_q <= '0;
      end
      S_RNXT: cur_q <= lspv_pkg::to_q23(cfg_i.sample_format, rdata_q);
      S_MUL1: begin
        nv_q <= has_q ? lspv_pkg::to_q23(cfg_i.sample_format, rdata_q) : 24'sd0;
        pa_q <= cur_q * $signed({1'b0, FracOne - mix_q});
      end
      S_MUL2: pb_q <= nv_q * $signed({1'b0, mix_q});
      S_SUM: begin
        frame_q  <= rnd_c[FB+23:FB];
        dq_q     <= vwn_c - VW'(le_c);
        rem_q    <= '0;
        period_q <= (lm_q == lspv_pkg::LOOP_FWD) ? 14'(span_c)
                    : {span_c, 1'b0} - 14'd2;
      end
      S_DIV: begin
        dq_q  <= dq_q << 1;
        rem_q <= (remsh_c >= {1'b0, period_q}) ? remsh_c - {1'b0, period_q} : remsh_c;
      end
      S_OUT: begin
        if (!rsp_valid_q || rsp.ready) begin
          rsp_frame_q  <= frame_q;
          rsp_active_q <= playing_q;
          rsp_ended_q  <= ended_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign rsp.valid        = rsp_valid_q;
  assign rsp.frame_value  = rsp_frame_q;
  assign rsp.voice_active = rsp_active_q;
  assign rsp.voice_ended  = rsp_ended_q;

  a_div_only_looped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> lm_q != lspv_pkg::LOOP_OFF)
    else $error("divider runs without a loop");

  a_rem_below_period: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_FOLD |-> rem_q < {1'b0, period_q})
    else $error("loop residue not reduced");

  a_ended_inactive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_q && rsp_ended_q |-> !rsp_active_q)
    else $error("ended voice still active");

  a_pop_in_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> state_q != S_IDLE)
    else $error("popped item not taken up");

endmodule

### rtl/core/looped_sample_playback_voice.sv
// Looped sample playback voice. Load, start and idle commands go from the queue straight
// to the result stage; a render steps through two memory reads, two multiplies and a sum,
// plus a 20-step serial modulo and a fold when a loop wraps. The back-end sequencer takes
// one item at a time; a 2-entry queue lets the input take items while results wait.
// Reset clears position, direction and playing, and sets registers to defaults
// (format 16-bit); the sample memory keeps its contents and is not cleared.
module looped_sample_playback_voice (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  lspv_in_if.sink                         req_i,
  lspv_out_if.source                      rsp_o,
  input  logic                            cfg_we_i,
  input  logic [lspv_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [lspv_pkg::CfgDataW-1:0]   cfg_data_i
);

  lspv_pkg::cfg_t    cfg_q;
  lspv_pkg::push_t   push;
  lspv_pkg::item_t   head;
  lspv_pkg::q_stat_t q_stat;
  logic              pop;

  // Configuration register file; writes to unused indexes drop.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wrap_mode      <= lspv_pkg::LOOP_OFF;
      cfg_q.loop_first     <= '0;
      cfg_q.loop_last_excl <= '0;
      cfg_q.sample_length  <= '0;
      cfg_q.sample_format  <= lspv_pkg::FMT_S16;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        lspv_pkg::REG_LOOP_MODE:  cfg_q.wrap_mode      <= cfg_data_i[1:0];
        lspv_pkg::REG_LOOP_FIRST: cfg_q.loop_first     <= cfg_data_i[lspv_pkg::AddrW-1:0];
        lspv_pkg::REG_LOOP_LAST:  cfg_q.loop_last_excl <= cfg_data_i;
        lspv_pkg::REG_LENGTH:     cfg_q.sample_length  <= cfg_data_i;
        lspv_pkg::REG_FORMAT:     cfg_q.sample_format  <= cfg_data_i[1:0];
        default: begin
        end
      endcase
    end
  end

  // Decode and queue each transfer.
  lspv_front u_front (
    .req      (req_i),
    .q_stat_i (q_stat),
    .push_o   (push)
  );

  lspv_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  // Execute commands in order and hold each result until transferred.
  lspv_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .head_i    (head),
    .q_empty_i (q_stat.empty),
    .pop_o     (pop),
    .rsp       (rsp_o)
  );

endmodule
